// ===== design/atlb_pkg.sv =====
package atlb_pkg;

   // fixed field widths
   localparam int BYTE_W = 8;
   localparam int HT_W   = 12;
   localparam int COV_W  = 9;
   localparam int IDX_W  = 3;
   localparam logic [COV_W-1:0] COV_ONE = COV_W'(256);

   // register indexes
   localparam logic [IDX_W-1:0] IDX_BEGIN_ROW = 3'd0;
   localparam logic [IDX_W-1:0] IDX_BEGIN_COL = 3'd1;
   localparam logic [IDX_W-1:0] IDX_END_ROW   = 3'd2;
   localparam logic [IDX_W-1:0] IDX_END_COL   = 3'd3;
   localparam logic [IDX_W-1:0] IDX_HALF_TH   = 3'd4;
   localparam logic [IDX_W-1:0] IDX_LINE      = 3'd5;
   localparam logic [IDX_W-1:0] IDX_GAMMA     = 3'd6;

   typedef logic [15:0] lut_type [256];

   // decode of one gray code to linear light, evaluated at elaboration
   function automatic logic [15:0] lin_decode(int lin_bits, bit gamma2, int v);
      longint unsigned lm;
      longint unsigned vv;
      longint unsigned y;
      longint unsigned y2;
      longint unsigned r;
      longint unsigned p;
      longint unsigned cand;
      longint unsigned r2;
      longint unsigned p5;
      lm = (64'd1 << lin_bits) - 64'd1;
      vv = longint'(v);
      if (gamma2) begin
         return 16'((64'd2 * lm * vv * vv + 64'd65025) / 64'd130050);
      end
      if (vv <= 64'd10) begin
         return 16'((64'd2 * lm * vv * 64'd100 + 64'd329460) / 64'd658920);
      end
      y  = ((64'd1000 * vv + 64'd14025) << 30) / 64'd269025;
      y2 = (y * y) >> 30;
      r  = 64'd0;
      for (int b = 30; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         r2   = (cand * cand) >> 30;
         p5   = (((r2 * r2) >> 30) * cand) >> 30;
         if (cand <= (64'd1 << 30) && p5 <= y2) r = cand;
      end
      p = (y2 * r) >> 30;
      return 16'((p * lm + (64'd1 << 29)) >> 30);
   endfunction

   function automatic lut_type build_lut(int lin_bits, bit gamma2);
      lut_type t;
      for (int v = 0; v < 256; v++) t[v] = lin_decode(lin_bits, gamma2, v);
      return t;
   endfunction

endpackage

// ===== design/atlb_cfg.sv =====
module atlb_cfg #(
   parameter int PW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [atlb_pkg::IDX_W-1:0]    csr_index,
   input  logic [PW-1:0]                 csr_wr_data,
   output logic [PW-1:0]                 begin_row,
   output logic [PW-1:0]                 begin_col,
   output logic signed [PW:0]            dr,
   output logic signed [PW:0]            dc,
   output logic [2*PW:0]                 l2,
   output logic [(2*PW+16)/2-1:0]        root,
   output logic [atlb_pkg::HT_W-1:0]     half_thickness,
   output logic [atlb_pkg::BYTE_W-1:0]   line_brightness,
   output logic                          gamma_mode,
   output logic                          busy
);
   import atlb_pkg::*;

   localparam int L2_W  = 2*PW + 1;
   localparam int SQ_W  = (L2_W + 15) / 2;
   localparam int CNT_W = $clog2(SQ_W + 1);

   logic [PW-1:0]      br_ff, bc_ff, er_ff, ec_ff;
   logic [HT_W-1:0]    ht_ff;
   logic [BYTE_W-1:0]  lb_ff;
   logic               gm_ff;
   logic signed [PW:0] dr_ff, dc_ff, dr_in, dc_in;
   logic [L2_W-1:0]    l2_ff, l2_in;
   logic [SQ_W-1:0]    root_ff, trial_in;
   logic [2*SQ_W-1:0]  sq_in, x_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               pend_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         br_ff <= '0;
         bc_ff <= '0;
         er_ff <= '0;
         ec_ff <= '0;
         ht_ff <= '0;
         lb_ff <= '1;
         gm_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            IDX_BEGIN_ROW: br_ff <= csr_wr_data;
            IDX_BEGIN_COL: bc_ff <= csr_wr_data;
            IDX_END_ROW:   er_ff <= csr_wr_data;
            IDX_END_COL:   ec_ff <= csr_wr_data;
            IDX_HALF_TH:   ht_ff <= HT_W'(csr_wr_data);
            IDX_LINE:      lb_ff <= BYTE_W'(csr_wr_data);
            IDX_GAMMA:     gm_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // direction and squared length, refreshed every cycle
   always_comb begin
      dr_in = $signed({1'b0, er_ff}) - $signed({1'b0, br_ff});
      dc_in = $signed({1'b0, ec_ff}) - $signed({1'b0, bc_ff});
      l2_in = L2_W'(dr_in * dr_in) + L2_W'(dc_in * dc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dr_ff <= '0;
         dc_ff <= '0;
         l2_ff <= '0;
      end else begin
         dr_ff <= dr_in;
         dc_ff <= dc_in;
         l2_ff <= l2_in;
      end
   end

   // bit-serial square root of l2 scaled by 2^14, one root bit a cycle
   always_comb begin
      trial_in = root_ff | (SQ_W'(1) << (cnt_ff - CNT_W'(1)));
      sq_in    = trial_in * trial_in;
      x_in     = (2*SQ_W)'(l2_ff) << 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         cnt_ff  <= '0;
         root_ff <= '0;
      end else begin
         pend_ff <= csr_wr_en;
         if (pend_ff) begin
            cnt_ff  <= CNT_W'(SQ_W);
            root_ff <= '0;
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (sq_in <= x_in) root_ff <= trial_in;
         end
      end
   end

   assign begin_row       = br_ff;
   assign begin_col       = bc_ff;
   assign dr              = dr_ff;
   assign dc              = dc_ff;
   assign l2              = l2_ff;
   assign root            = root_ff;
   assign half_thickness  = ht_ff;
   assign line_brightness = lb_ff;
   assign gamma_mode      = gm_ff;
   assign busy            = csr_wr_en | pend_ff | (cnt_ff != '0);

endmodule

// ===== design/atlb_geom.sv =====
module atlb_geom #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  logic                                    in_valid,
   input  logic [COORD_BITS-1:0]                   row,
   input  logic [COORD_BITS-1:0]                   col,
   input  logic [atlb_pkg::BYTE_W-1:0]             bg,
   input  logic [COORD_BITS+FRAC_BITS-1:0]         begin_row,
   input  logic [COORD_BITS+FRAC_BITS-1:0]         begin_col,
   input  logic signed [COORD_BITS+FRAC_BITS:0]    dr,
   input  logic signed [COORD_BITS+FRAC_BITS:0]    dc,
   input  logic [2*(COORD_BITS+FRAC_BITS):0]       l2,
   output logic                                    out_valid,
   output logic [2*(COORD_BITS+FRAC_BITS)+17-FRAC_BITS:0] num_perp,
   output logic [2*(COORD_BITS+FRAC_BITS)+17-FRAC_BITS:0] num_ov,
   output logic [atlb_pkg::BYTE_W+1:0]             side
);
   import atlb_pkg::*;

   localparam int PW    = COORD_BITS + FRAC_BITS;
   localparam int D_W   = PW + 1;
   localparam int M_W   = 2 * D_W;
   localparam int T_W   = M_W + 1;
   localparam int L2_W  = 2*PW + 1;
   localparam int SH    = 15 - FRAC_BITS;
   localparam int NUM_W = T_W + SH;

   logic [3:0]              v_ff;
   logic [BYTE_W-1:0]       bg_ff [4];
   logic [PW-1:0]           pos_r_in, pos_c_in;
   logic signed [D_W-1:0]   qr_ff, qc_ff;
   logic signed [M_W-1:0]   prr_ff, pcc_ff, prc_ff, pcr_ff;
   logic signed [T_W-1:0]   t_ff, cross_ff, l2s_in;
   logic [T_W-1:0]          mag_in, u_in;
   logic                    inside_in;
   logic [NUM_W-1:0]        np_ff, no_ff;
   logic                    zero_ff, inside_ff;

   assign pos_r_in = PW'(row) << FRAC_BITS;
   assign pos_c_in = PW'(col) << FRAC_BITS;

   // offsets relative to the begin point, products, dot and cross, classification
   always_comb begin
      l2s_in    = T_W'($signed({1'b0, l2}));
      inside_in = !t_ff[T_W-1] && (t_ff <= l2s_in);
      mag_in    = cross_ff[T_W-1] ? T_W'(-cross_ff) : T_W'(cross_ff);
      u_in      = t_ff[T_W-1] ? T_W'(-t_ff) : T_W'(t_ff - l2s_in);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qr_ff     <= $signed({1'b0, pos_r_in}) - $signed({1'b0, begin_row});
         qc_ff     <= $signed({1'b0, pos_c_in}) - $signed({1'b0, begin_col});
         bg_ff[0]  <= bg;
         prr_ff    <= qr_ff * dr;
         pcc_ff    <= qc_ff * dc;
         prc_ff    <= qr_ff * dc;
         pcr_ff    <= qc_ff * dr;
         bg_ff[1]  <= bg_ff[0];
         t_ff      <= T_W'(prr_ff) + T_W'(pcc_ff);
         cross_ff  <= T_W'(prc_ff) - T_W'(pcr_ff);
         bg_ff[2]  <= bg_ff[1];
         np_ff     <= NUM_W'(mag_in) << SH;
         no_ff     <= NUM_W'(u_in) << SH;
         zero_ff   <= (l2 == '0);
         inside_ff <= inside_in;
         bg_ff[3]  <= bg_ff[2];
      end
   end

   assign out_valid = v_ff[3];
   assign num_perp  = np_ff;
   assign num_ov    = no_ff;
   assign side      = {zero_ff, inside_ff, bg_ff[3]};

endmodule

// ===== design/atlb_div.sv =====
module atlb_div #(
   parameter int NUM_W  = 46,
   parameter int SQ_W   = 24,
   parameter int QW     = 17,
   parameter int SIDE_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num_a,
   input  logic [NUM_W-1:0]  num_b,
   input  logic [SQ_W-1:0]   divisor,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QW-1:0]     quo_a,
   output logic [QW-1:0]     quo_b,
   output logic [SIDE_W-1:0] side_out
);

   localparam int CMP_W = NUM_W + SQ_W + QW;

   logic [QW:0]         v_ff, sa_ff, sb_ff;
   logic [NUM_W-1:0]    ra_ff [QW+1], rb_ff [QW+1], ra_in [QW+1], rb_in [QW+1];
   logic [QW-1:0]       qa_ff [QW+1], qb_ff [QW+1], qa_in [QW+1], qb_in [QW+1];
   logic [SIDE_W-1:0]   side_ff [QW+1];
   logic [CMP_W-1:0]    limit_in, sub_in;

   // quotients that do not fit saturate to all ones
   assign limit_in = CMP_W'(divisor) << QW;

   // restoring division, one quotient bit per stage, two lanes
   always_comb begin
      ra_in[0] = num_a;
      rb_in[0] = num_b;
      qa_in[0] = '0;
      qb_in[0] = '0;
      sub_in   = '0;
      for (int k = 1; k <= QW; k++) begin
         sub_in = CMP_W'(divisor) << (QW - k);
         if (CMP_W'(ra_ff[k-1]) >= sub_in) begin
            ra_in[k] = NUM_W'(CMP_W'(ra_ff[k-1]) - sub_in);
            qa_in[k] = qa_ff[k-1] | (QW'(1) << (QW - k));
         end else begin
            ra_in[k] = ra_ff[k-1];
            qa_in[k] = qa_ff[k-1];
         end
         if (CMP_W'(rb_ff[k-1]) >= sub_in) begin
            rb_in[k] = NUM_W'(CMP_W'(rb_ff[k-1]) - sub_in);
            qb_in[k] = qb_ff[k-1] | (QW'(1) << (QW - k));
         end else begin
            rb_in[k] = rb_ff[k-1];
            qb_in[k] = qb_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[QW-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff      <= {sa_ff[QW-1:0], (CMP_W'(num_a) >= limit_in)};
         sb_ff      <= {sb_ff[QW-1:0], (CMP_W'(num_b) >= limit_in)};
         side_ff[0] <= side_in;
         for (int k = 0; k <= QW; k++) begin
            ra_ff[k] <= ra_in[k];
            rb_ff[k] <= rb_in[k];
            qa_ff[k] <= qa_in[k];
            qb_ff[k] <= qb_in[k];
         end
         for (int k = 1; k <= QW; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = v_ff[QW];
   assign quo_a     = sa_ff[QW] ? '1 : qa_ff[QW];
   assign quo_b     = sb_ff[QW] ? '1 : qb_ff[QW];
   assign side_out  = side_ff[QW];

endmodule

// ===== design/atlb_blend.sv =====
module atlb_blend #(
   parameter int LINEAR_BITS = 12,
   parameter int FRAC_BITS   = 4
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       adv,
   input  logic                                       in_valid,
   input  logic [atlb_pkg::HT_W+8-FRAC_BITS:0]        perp,
   input  logic [atlb_pkg::HT_W+8-FRAC_BITS:0]        ov,
   input  logic [atlb_pkg::BYTE_W+1:0]                side,
   input  logic [atlb_pkg::HT_W-1:0]                  half_thickness,
   input  logic [atlb_pkg::BYTE_W-1:0]                line_brightness,
   input  logic                                       gamma_mode,
   output logic                                       out_valid,
   output logic [atlb_pkg::BYTE_W-1:0]                pixel_value,
   output logic                                       covered
);
   import atlb_pkg::*;

   localparam int QW  = HT_W + 9 - FRAC_BITS;
   localparam int LB  = LINEAR_BITS;
   localparam int P_W = LB + COV_W;
   localparam int NS  = 12;
   localparam lut_type SRGB_LUT  = build_lut(LINEAR_BITS, 1'b0);
   localparam lut_type GAMMA_LUT = build_lut(LINEAR_BITS, 1'b1);

   function automatic logic [LB-1:0] lut_read(logic mode, logic [BYTE_W-1:0] idx);
      return mode ? LB'(GAMMA_LUT[idx]) : LB'(SRGB_LUT[idx]);
   endfunction

   logic [NS-1:0]        v_ff;
   logic [QW-1:0]        th_in, lim_in, ovr_in;
   logic [COV_W-1:0]     c_in, c_ff [3];
   logic [BYTE_W-1:0]    bg_ff [3];
   logic [LB-1:0]        da_ff, dl_ff, lin_in;
   logic [P_W-1:0]       pa_ff, pl_ff;
   logic [P_W:0]         sum_in;
   logic [LB-1:0]        sl_ff [9];
   logic [BYTE_W-1:0]    se_ff [9], sb_ff [9], se_in [9];
   logic [8:0]           sc_ff;

   // coverage from perpendicular distance and end overshoot
   always_comb begin
      th_in  = QW'(half_thickness) << (8 - FRAC_BITS);
      lim_in = th_in + QW'(256);
      ovr_in = perp - th_in;
      if (side[BYTE_W+1]) begin
         c_in = '0;
      end else if (side[BYTE_W]) begin
         if (perp >= lim_in)     c_in = '0;
         else if (perp <= th_in) c_in = COV_ONE;
         else                    c_in = COV_W'(QW'(256) - ovr_in);
      end else begin
         if (ov > QW'(256) || perp >= lim_in) c_in = '0;
         else                                  c_in = COV_W'(QW'(256) - ov);
      end
   end

   // blend in linear light, rounded
   always_comb begin
      sum_in = (P_W+1)'(pa_ff) + (P_W+1)'(pl_ff) + (P_W+1)'(128);
      lin_in = LB'(sum_in >> 8);
   end

   // binary search for the largest code whose decode stays at or below lin
   always_comb begin
      se_in[0] = '0;
      for (int j = 1; j <= 8; j++) begin
         if (lut_read(gamma_mode, se_ff[j-1] | (BYTE_W'(1) << (8 - j))) <= sl_ff[j-1])
            se_in[j] = se_ff[j-1] | (BYTE_W'(1) << (8 - j));
         else
            se_in[j] = se_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff[0]  <= c_in;
         bg_ff[0] <= side[BYTE_W-1:0];
         da_ff    <= lut_read(gamma_mode, bg_ff[0]);
         dl_ff    <= lut_read(gamma_mode, line_brightness);
         c_ff[1]  <= c_ff[0];
         bg_ff[1] <= bg_ff[0];
         pa_ff    <= da_ff * (COV_ONE - c_ff[1]);
         pl_ff    <= dl_ff * c_ff[1];
         c_ff[2]  <= c_ff[1];
         bg_ff[2] <= bg_ff[1];
         sl_ff[0] <= lin_in;
         se_ff[0] <= '0;
         sb_ff[0] <= bg_ff[2];
         sc_ff[0] <= (c_ff[2] != '0);
         for (int j = 1; j <= 8; j++) begin
            sl_ff[j] <= sl_ff[j-1];
            se_ff[j] <= se_in[j];
            sb_ff[j] <= sb_ff[j-1];
            sc_ff[j] <= sc_ff[j-1];
         end
      end
   end

   assign out_valid   = v_ff[NS-1];
   assign pixel_value = sc_ff[8] ? se_ff[8] : sb_ff[8];
   assign covered     = sc_ff[8];

endmodule

// ===== design/antialiased_thick_line_pixel_blend.sv =====
// pipeline: 4 geometry stages, HT_W+10-FRAC_BITS divider stages and 12 blend stages
// throughput: one pixel per cycle while the result side takes beats and no square root is running
// after each register write the square root of the segment length runs bit-serially:
//   req_tready stays low from the write until the square root is done
// synchronous reset clears the pipeline valid bits and loads the register reset values
module antialiased_thick_line_pixel_blend #(
   parameter int COORD_BITS  = 12,
   parameter int FRAC_BITS   = 4,
   parameter int LINEAR_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // pixel_row, pixel_col, background
   input  logic [((2*COORD_BITS+8+7)/8)*8-1:0]     req_tdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // pixel_value
   output logic [atlb_pkg::BYTE_W-1:0]             rsp_tdata,
   // covered
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_wr_en,
   input  logic [atlb_pkg::IDX_W-1:0]              csr_index,
   input  logic [COORD_BITS+FRAC_BITS-1:0]         csr_wr_data
);
   import atlb_pkg::*;

   localparam int PW     = COORD_BITS + FRAC_BITS;
   localparam int L2_W   = 2*PW + 1;
   localparam int SQ_W   = (L2_W + 15) / 2;
   localparam int NUM_W  = 2*(PW+1) + 1 + 15 - FRAC_BITS;
   localparam int QW     = HT_W + 9 - FRAC_BITS;
   localparam int SIDE_W = BYTE_W + 2;

   logic                 adv, busy, in_valid;
   logic [PW-1:0]        begin_row, begin_col;
   logic signed [PW:0]   dr, dc;
   logic [L2_W-1:0]      l2;
   logic [SQ_W-1:0]      root;
   logic [HT_W-1:0]      half_thickness;
   logic [BYTE_W-1:0]    line_brightness;
   logic                 gamma_mode;
   logic                 g_valid, d_valid;
   logic [NUM_W-1:0]     num_perp, num_ov;
   logic [SIDE_W-1:0]    g_side, d_side;
   logic [QW-1:0]        perp, ov;

   // whole pipeline moves unless the output beat is stalled
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !busy;
   assign in_valid   = req_tvalid && req_tready;

   atlb_cfg #(.PW(PW)) u_cfg (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .begin_row       (begin_row),
      .begin_col       (begin_col),
      .dr              (dr),
      .dc              (dc),
      .l2              (l2),
      .root            (root),
      .half_thickness  (half_thickness),
      .line_brightness (line_brightness),
      .gamma_mode      (gamma_mode),
      .busy            (busy)
   );

   atlb_geom #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid),
      .row       (req_tdata[COORD_BITS-1:0]),
      .col       (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .bg        (req_tdata[2*COORD_BITS+BYTE_W-1:2*COORD_BITS]),
      .begin_row (begin_row),
      .begin_col (begin_col),
      .dr        (dr),
      .dc        (dc),
      .l2        (l2),
      .out_valid (g_valid),
      .num_perp  (num_perp),
      .num_ov    (num_ov),
      .side      (g_side)
   );

   atlb_div #(.NUM_W(NUM_W), .SQ_W(SQ_W), .QW(QW), .SIDE_W(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (g_valid),
      .num_a     (num_perp),
      .num_b     (num_ov),
      .divisor   (root),
      .side_in   (g_side),
      .out_valid (d_valid),
      .quo_a     (perp),
      .quo_b     (ov),
      .side_out  (d_side)
   );

   atlb_blend #(.LINEAR_BITS(LINEAR_BITS), .FRAC_BITS(FRAC_BITS)) u_blend (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (d_valid),
      .perp            (perp),
      .ov              (ov),
      .side            (d_side),
      .half_thickness  (half_thickness),
      .line_brightness (line_brightness),
      .gamma_mode      (gamma_mode),
      .out_valid       (rsp_tvalid),
      .pixel_value     (rsp_tdata),
      .covered         (rsp_tuser)
   );

endmodule
